FILE: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// shared constants and types of the cosine hemisphere sampler
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int UBitsDef = 16;
  localparam int QuadStages = 6;

  // taylor coefficients of sin(pi/2 x), q30 magnitudes
  localparam logic [31:0] Tc1 = 32'd1686629713;
  localparam logic [31:0] Tc3 = 32'd693598668;
  localparam logic [31:0] Tc5 = 32'd85569306;
  localparam logic [31:0] Tc7 = 32'd5026995;
  localparam logic [31:0] Tc9 = 32'd172272;
  localparam logic [31:0] InvPiQ32 = 32'd1367130551;

  typedef struct packed {
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [14:0] dir_z;
    logic [14:0] density;
  } res_t;

endpackage

FILE: rtl/chs_if.sv
// ----------------------------------------------------------------------------
// chs_in_if / chs_out_if
// valid/ready channels of the sampler
// ----------------------------------------------------------------------------
interface chs_in_if #(parameter int U_BITS = chs_pkg::UBitsDef);
  logic valid;
  logic ready;
  logic [U_BITS-1:0] u_radial;
  logic [U_BITS-1:0] u_angle;
  modport source (output valid, u_radial, u_angle, input ready);
  modport sink (input valid, u_radial, u_angle, output ready);
endinterface

interface chs_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic [14:0] dir_z;
  logic [14:0] density;
  modport source (output valid, dir_x, dir_y, dir_z, density, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, density, output ready);
endinterface

FILE: rtl/cosine_hemisphere_sampler.sv
// ----------------------------------------------------------------------------
// cosine_hemisphere_sampler
// cosine-weighted hemisphere direction and density from two uniform fractions
// ----------------------------------------------------------------------------
// Fully pipelined: one request is accepted every cycle unless the output stalls,
// and its result passes the load stage, 32 square-root stages that each retire
// one result bit, and two output stages. The polynomial for sin and cos runs in
// parallel stages beside the square roots. The pipeline advances as a whole
// when the output is empty or taken; a stall freezes every stage, so nothing is lost.
module cosine_hemisphere_sampler #(
  parameter int U_BITS = chs_pkg::UBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  chs_in_if.sink   in_ch,
  chs_out_if.source out_ch
);

  localparam int NS = 32;                   // square root stages
  localparam int ND = NS + 3;               // load stage, root stages, two output stages
  localparam int NQ = chs_pkg::QuadStages;  // polynomial stages
  localparam int NT = NS - NQ;              // trig delay stages

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic [ND-1:0] vld_r;

  // operands as q62 radicands
  logic [62:0] rad_c, rad_s;
  logic [U_BITS:0] full_minus;
  assign full_minus = (U_BITS+1)'(1) << U_BITS;
  assign rad_c = 63'(in_ch.u_radial) << (62 - U_BITS);
  assign rad_s = 63'(full_minus - {1'b0, in_ch.u_radial}) << (62 - U_BITS);

  // square root pipeline (restoring, two radicand bits per stage)
  logic [63:0] rc_r [NS+1];
  logic [63:0] qc_r [NS+1];
  logic [63:0] rs_r [NS+1];
  logic [63:0] qs_r [NS+1];
  logic [31:0] t_r  [NS+1];

  // phase of the azimuth, q32 turn fraction
  logic [31:0] t_in;
  assign t_in = 32'(in_ch.u_angle) << (32 - U_BITS);

  // trig polynomial pipeline on quadrant fraction
  logic [30:0] fs_r [NQ+1];
  logic [30:0] fc_r [NQ+1];
  logic [30:0] x2s_r [NQ+1];
  logic [30:0] x2c_r [NQ+1];
  logic signed [32:0] ps_r [NQ+1];
  logic signed [32:0] pc_r [NQ+1];

  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                               input logic [30:0] b);
    logic [32:0] mag;
    logic [63:0] p;
    mag = a[32] ? 33'(-a) : 33'(a);
    p = 64'(mag) * 64'(b);
    p = p >> 30;
    mulq = a[32] ? -33'(p) : 33'(p);
  endfunction

  function automatic logic signed [32:0] coef(input int k);
    unique case (k)
      1: coef = -$signed({1'b0, chs_pkg::Tc7});
      2: coef = $signed({1'b0, chs_pkg::Tc5});
      3: coef = -$signed({1'b0, chs_pkg::Tc3});
      4: coef = $signed({1'b0, chs_pkg::Tc1});
      default: coef = '0;
    endcase
  endfunction

  // stage 0 load
  always_ff @(posedge clk) begin
    if (adv) begin
      rc_r[0] <= 64'(rad_c);
      rs_r[0] <= 64'(rad_s);
      qc_r[0] <= '0;
      qs_r[0] <= '0;
      t_r[0]  <= t_in;
      fs_r[0] <= {1'b0, t_in[29:0]};
      fc_r[0] <= 31'(32'h4000_0000 - {2'b00, t_in[29:0]});
      x2s_r[0] <= '0;
      x2c_r[0] <= '0;
      ps_r[0] <= $signed({1'b0, chs_pkg::Tc9});
      pc_r[0] <= $signed({1'b0, chs_pkg::Tc9});
    end
  end

  // square root stages: trial bit of weight 4^(31-i)
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    localparam logic [63:0] StepBit = 64'(1) << (62 - 2*i);
    logic [63:0] trc, trs;
    assign trc = qc_r[i] + StepBit;
    assign trs = qs_r[i] + StepBit;
    always_ff @(posedge clk) begin
      if (adv) begin
        t_r[i+1] <= t_r[i];
        if (rc_r[i] >= trc) begin
          rc_r[i+1] <= rc_r[i] - trc;
          qc_r[i+1] <= (qc_r[i] >> 1) + StepBit;
        end else begin
          rc_r[i+1] <= rc_r[i];
          qc_r[i+1] <= qc_r[i] >> 1;
        end
        if (rs_r[i] >= trs) begin
          rs_r[i+1] <= rs_r[i] - trs;
          qs_r[i+1] <= (qs_r[i] >> 1) + StepBit;
        end else begin
          rs_r[i+1] <= rs_r[i];
          qs_r[i+1] <= qs_r[i] >> 1;
        end
      end
    end
  end

  logic [31:0] cos_root, sin_root;
  assign cos_root = qc_r[NS][31:0];
  assign sin_root = qs_r[NS][31:0];

  // polynomial stages, x2 then four horner steps then final times x
  for (genvar k = 0; k < NQ; k++) begin : g_poly
    always_ff @(posedge clk) begin
      if (adv) begin
        fs_r[k+1] <= fs_r[k];
        fc_r[k+1] <= fc_r[k];
        if (k == 0) begin
          x2s_r[1] <= 31'((64'(fs_r[0]) * 64'(fs_r[0])) >> 30);
          x2c_r[1] <= 31'((64'(fc_r[0]) * 64'(fc_r[0])) >> 30);
          ps_r[1] <= ps_r[0];
          pc_r[1] <= pc_r[0];
        end else if (k < 5) begin
          x2s_r[k+1] <= x2s_r[k];
          x2c_r[k+1] <= x2c_r[k];
          ps_r[k+1] <= coef(k) + mulq(ps_r[k], x2s_r[k]);
          pc_r[k+1] <= coef(k) + mulq(pc_r[k], x2c_r[k]);
        end else begin
          x2s_r[k+1] <= x2s_r[k];
          x2c_r[k+1] <= x2c_r[k];
          ps_r[k+1] <= mulq(ps_r[k], fs_r[k]);
          pc_r[k+1] <= mulq(pc_r[k], fc_r[k]);
        end
      end
    end
  end

  // delay trig results to meet the square roots
  logic [30:0] sd_r [NT];
  logic [30:0] cd_r [NT];
  logic [30:0] s_cl, c_cl;
  assign s_cl = ps_r[NQ][32] ? '0 :
                (ps_r[NQ] > 33'sh4000_0000) ? 31'h4000_0000 : 31'(ps_r[NQ]);
  assign c_cl = pc_r[NQ][32] ? '0 :
                (pc_r[NQ] > 33'sh4000_0000) ? 31'h4000_0000 : 31'(pc_r[NQ]);
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= s_cl;
      cd_r[0] <= c_cl;
      for (int j = 1; j < NT; j++) begin
        sd_r[j] <= sd_r[j-1];
        cd_r[j] <= cd_r[j-1];
      end
    end
  end

  // output stage 1: products
  logic [1:0]  q_r;
  logic [62:0] px_r, py_r, pd_r;
  logic [31:0] cq_r;
  logic [30:0] xt, yt;
  logic [1:0]  qn;
  assign qn = t_r[NS][31:30];
  always_comb begin
    unique case (qn)
      2'd0: begin xt = cd_r[NT-1]; yt = sd_r[NT-1]; end
      2'd1: begin xt = sd_r[NT-1]; yt = cd_r[NT-1]; end
      2'd2: begin xt = cd_r[NT-1]; yt = sd_r[NT-1]; end
      default: begin xt = sd_r[NT-1]; yt = cd_r[NT-1]; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      q_r  <= qn;
      px_r <= 63'(64'(sin_root) * 64'(xt));
      py_r <= 63'(64'(sin_root) * 64'(yt));
      pd_r <= 63'(64'(cos_root) * 64'(chs_pkg::InvPiQ32));
      cq_r <= cos_root;
    end
  end

  // output stage 2: rounding, saturation, sign
  function automatic logic [15:0] comp(input logic [62:0] p, input logic neg);
    logic [17:0] m;
    logic [15:0] s;
    m = 18'((64'(p) + (64'(1) << 45)) >> 46);
    s = (m > 18'd32767) ? 16'd32767 : m[15:0];
    comp = neg ? 16'(-s) : s;
  endfunction

  logic [16:0] zr;
  logic [17:0] dr;
  assign zr = 17'((33'(cq_r) + 33'h8000) >> 16);
  assign dr = 18'((64'(pd_r) + (64'(1) << 46)) >> 47);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.dir_x <= comp(px_r, q_r == 2'd1 || q_r == 2'd2);
      out_ch.dir_y <= comp(py_r, q_r == 2'd2 || q_r == 2'd3);
      out_ch.dir_z <= (zr > 17'd32767) ? 15'h7FFF : zr[14:0];
      out_ch.density <= (dr > 18'd32767) ? 15'h7FFF : dr[14:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[ND-2:0], in_ch.valid};
  end
  assign out_ch.valid = vld_r[ND-1];

  // assertions
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.dir_z))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("not ready with empty output");
  a_zmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.density <= 15'd20861)
    else $error("density out of range");

endmodule
